FILE: design/pffa_pkg.sv
package pffa_pkg;

   // Request kinds
   localparam logic [2:0] ACT_ALLOC     = 3'd0;
   localparam logic [2:0] ACT_FREE      = 3'd1;
   localparam logic [2:0] ACT_RESERVE   = 3'd2;
   localparam logic [2:0] ACT_UNRESERVE = 3'd3;
   localparam logic [2:0] ACT_LOAD      = 3'd4;
   localparam logic [2:0] ACT_QUERY     = 3'd5;
   localparam logic [2:0] ACT_BUCKET    = 3'd6;

   // Completion codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_OOM     = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_LOWEST_PAGE = 2'd0;
   localparam logic [1:0] REG_TOTAL_PAGES = 2'd1;
   localparam logic [1:0] REG_FREE_CODE   = 2'd2;

   localparam int PAGE_SHIFT = 12;
   localparam logic [16:0] CNT_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [35:0] lowest_page;
      logic [16:0] total_pages;
      logic [7:0]  free_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] base_address;
      logic [7:0]  entry_type;
      logic [3:0]  entry_bucket;
      logic [16:0] free_count;
      logic [16:0] used_count;
      logic [16:0] reserved_count;
   } result_type;

   // Saturating page counter add
   function automatic logic [16:0] sat_add(logic [16:0] a, logic [16:0] b);
      logic [17:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[17] ? CNT_MAX : s[16:0];
   endfunction

endpackage

FILE: design/pffa_ram.sv
module pffa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pffa_engine.sv
module pffa_engine #(
   parameter int NUM_PAGES = 65536,
   parameter int TYPE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pffa_pkg::cfg_type    cfg,
   input  logic                 start,
   input  logic [2:0]           action,
   input  logic [47:0]          address,
   input  logic [16:0]          page_count,
   input  logic [7:0]           page_type,
   input  logic [3:0]           bucket_size,
   output logic                 idle,
   output logic                 done,
   input  logic                 done_take,
   output pffa_pkg::result_type result
);

   localparam int IW = $clog2(NUM_PAGES);
   localparam int PW = $clog2(NUM_PAGES + 1);
   localparam int EW = TYPE_BITS + 4;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_CHK  = 7'b0000010,
      S_RD   = 7'b0000100,
      S_EV   = 7'b0001000,
      S_FILL = 7'b0010000,
      S_RSP  = 7'b0100000,
      S_CLR  = 7'b1000000
   } state_type;

   typedef enum logic [5:0] {
      M_HINT  = 6'b000001,
      M_FIRST = 6'b000010,
      M_SCAN  = 6'b000100,
      M_COUNT = 6'b001000,
      M_QUERY = 6'b010000,
      M_BKT   = 6'b100000
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   logic [2:0]           act_ff, act_in;
   logic                 aligned_ff, aligned_in;
   logic                 below_ff, below_in;
   logic [35:0]          idx_ff, idx_in;
   logic [16:0]          n_ff, n_in;
   logic [7:0]           ptype_ff, ptype_in;
   logic [3:0]           bkt_ff, bkt_in;
   logic [PW-1:0]        p_ff, p_in;
   logic [PW-1:0]        s_ff, s_in;
   logic [16:0]          r_ff, r_in;
   logic [16:0]          cnt_ff, cnt_in;
   logic [TYPE_BITS-1:0] wtype_ff, wtype_in;
   logic [PW-1:0]        hint_ff, hint_in;
   logic [16:0]          free_ff, free_in;
   logic [16:0]          used_ff, used_in;
   logic [16:0]          resv_ff, resv_in;
   logic [1:0]           status_ff, status_in;
   logic [47:0]          base_ff, base_in;
   logic [7:0]           etype_ff, etype_in;
   logic [3:0]           ebkt_ff, ebkt_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic                 rd_en;
   logic [EW-1:0]        rd_data;

   logic [PW-1:0]        lim;
   logic [TYPE_BITS-1:0] fc;
   logic [TYPE_BITS-1:0] rd_type;
   logic                 rd_free;
   logic                 bnd_ok;
   logic                 pg_ok;
   logic [35:0]          page;
   logic [16:0]          cnt_next;
   logic [35:0]          run_page;

   pffa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (p_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // Derived limits and lookups
   always_comb begin
      lim = (32'(cfg.total_pages) > 32'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(cfg.total_pages);
      fc = cfg.free_code[TYPE_BITS-1:0];
      rd_type = rd_data[EW-1:4];
      rd_free = (rd_type == fc);
      bnd_ok = !below_ff && (({1'b0, idx_ff} + 37'(n_ff)) <= 37'(lim));
      pg_ok = !below_ff && (idx_ff < 36'(lim));
      page = address[47:pffa_pkg::PAGE_SHIFT];
      cnt_next = cnt_ff + 17'(!rd_free);
      run_page = cfg.lowest_page + 36'(s_ff);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      act_in = act_ff;
      aligned_in = aligned_ff;
      below_in = below_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      ptype_in = ptype_ff;
      bkt_in = bkt_ff;
      p_in = p_ff;
      s_in = s_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      wtype_in = wtype_ff;
      hint_in = hint_ff;
      free_in = free_ff;
      used_in = used_ff;
      resv_in = resv_ff;
      status_in = status_ff;
      base_in = base_ff;
      etype_in = etype_ff;
      ebkt_in = ebkt_ff;
      wr_en = 1'b0;
      wr_addr = p_ff[IW-1:0];
      wr_data = {wtype_ff, 4'b0};
      rd_en = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            wr_en = 1'b1;
            wr_data = '0;
            p_in = p_ff + 1'b1;
            if (p_ff == PW'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               act_in = action;
               aligned_in = (address[pffa_pkg::PAGE_SHIFT-1:0] == '0);
               below_in = (page < cfg.lowest_page);
               idx_in = page - cfg.lowest_page;
               n_in = page_count;
               ptype_in = page_type;
               bkt_in = bucket_size;
               status_in = pffa_pkg::ST_INVALID;
               base_in = '0;
               etype_in = '0;
               ebkt_in = '0;
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            state_in = S_RSP;
            p_in = PW'(idx_ff);
            s_in = PW'(idx_ff);
            r_in = '0;
            cnt_in = '0;
            unique case (act_ff) inside
               pffa_pkg::ACT_ALLOC: begin
                  wtype_in = ptype_ff[TYPE_BITS-1:0];
                  if (n_ff == '0) begin
                     status_in = pffa_pkg::ST_INVALID;
                  end else if (free_ff < n_ff) begin
                     status_in = pffa_pkg::ST_OOM;
                  end else if (hint_ff >= lim) begin
                     mode_in = M_FIRST;
                     p_in = '0;
                     state_in = S_RD;
                  end else begin
                     mode_in = M_HINT;
                     p_in = hint_ff;
                     state_in = S_RD;
                  end
               end
               pffa_pkg::ACT_FREE, pffa_pkg::ACT_UNRESERVE: begin
                  wtype_in = fc;
                  if (!aligned_ff || !bnd_ok) begin
                     status_in = pffa_pkg::ST_INVALID;
                  end else if (n_ff == '0) begin
                     status_in = pffa_pkg::ST_OK;
                  end else begin
                     mode_in = M_COUNT;
                     state_in = S_RD;
                  end
               end
               pffa_pkg::ACT_RESERVE: begin
                  wtype_in = ptype_ff[TYPE_BITS-1:0];
                  if (!aligned_ff) begin
                     status_in = pffa_pkg::ST_INVALID;
                  end else if (n_ff > free_ff) begin
                     status_in = pffa_pkg::ST_OOM;
                  end else if (!bnd_ok) begin
                     status_in = pffa_pkg::ST_INVALID;
                  end else begin
                     status_in = pffa_pkg::ST_OK;
                     resv_in = pffa_pkg::sat_add(resv_ff, n_ff);
                     free_in = free_ff - n_ff;
                     if (n_ff != '0) begin
                        state_in = S_FILL;
                     end
                  end
               end
               pffa_pkg::ACT_LOAD: begin
                  wtype_in = ptype_ff[TYPE_BITS-1:0];
                  if (!aligned_ff || !bnd_ok) begin
                     status_in = pffa_pkg::ST_INVALID;
                  end else begin
                     status_in = pffa_pkg::ST_OK;
                     if (ptype_ff[TYPE_BITS-1:0] == fc) begin
                        free_in = pffa_pkg::sat_add(free_ff, n_ff);
                     end else if (ptype_ff[TYPE_BITS-1:0] != '0) begin
                        resv_in = pffa_pkg::sat_add(resv_ff, n_ff);
                     end
                     if (n_ff != '0) begin
                        state_in = S_FILL;
                     end
                  end
               end
               pffa_pkg::ACT_QUERY: begin
                  if (pg_ok) begin
                     mode_in = M_QUERY;
                     state_in = S_RD;
                  end
               end
               pffa_pkg::ACT_BUCKET: begin
                  if (pg_ok) begin
                     mode_in = M_BKT;
                     state_in = S_RD;
                  end
               end
               default: begin
                  status_in = pffa_pkg::ST_INVALID;
               end
            endcase
         end

         S_RD: begin
            rd_en = 1'b1;
            state_in = S_EV;
         end

         S_EV: begin
            state_in = S_RD;
            unique case (mode_ff)
               M_HINT: begin
                  if (rd_free) begin
                     mode_in = M_SCAN;
                     s_in = hint_ff;
                     p_in = hint_ff;
                     r_in = '0;
                     if ((32'(hint_ff) + 32'(n_ff)) > 32'(lim)) begin
                        status_in = pffa_pkg::ST_OOM;
                        state_in = S_RSP;
                     end
                  end else begin
                     mode_in = M_FIRST;
                     p_in = '0;
                  end
               end
               M_FIRST: begin
                  if (rd_free) begin
                     hint_in = p_ff;
                     mode_in = M_SCAN;
                     s_in = p_ff;
                     r_in = '0;
                     if ((32'(p_ff) + 32'(n_ff)) > 32'(lim)) begin
                        status_in = pffa_pkg::ST_OOM;
                        state_in = S_RSP;
                     end
                  end else begin
                     p_in = p_ff + 1'b1;
                     if ((p_ff + 1'b1) >= lim) begin
                        hint_in = lim;
                        status_in = pffa_pkg::ST_OOM;
                        state_in = S_RSP;
                     end
                  end
               end
               M_SCAN: begin
                  if (rd_free) begin
                     r_in = r_ff + 1'b1;
                     p_in = p_ff + 1'b1;
                     if ((r_ff + 1'b1) == n_ff) begin
                        // Run found: account and stamp it
                        status_in = pffa_pkg::ST_OK;
                        free_in = free_ff - n_ff;
                        used_in = pffa_pkg::sat_add(used_ff, n_ff);
                        base_in = {run_page, 12'b0};
                        p_in = s_ff;
                        r_in = '0;
                        state_in = S_FILL;
                     end
                  end else begin
                     s_in = p_ff + 1'b1;
                     p_in = p_ff + 1'b1;
                     r_in = '0;
                     if ((32'(p_ff) + 32'd1 + 32'(n_ff)) > 32'(lim)) begin
                        status_in = pffa_pkg::ST_OOM;
                        state_in = S_RSP;
                     end
                  end
               end
               M_COUNT: begin
                  cnt_in = cnt_next;
                  r_in = r_ff + 1'b1;
                  p_in = p_ff + 1'b1;
                  if ((r_ff + 1'b1) == n_ff) begin
                     state_in = S_RSP;
                     p_in = s_ff;
                     r_in = '0;
                     if (cnt_next == '0) begin
                        status_in = pffa_pkg::ST_OK;
                     end else if (act_ff == pffa_pkg::ACT_UNRESERVE && resv_ff < cnt_next) begin
                        status_in = pffa_pkg::ST_INVALID;
                     end else if (act_ff == pffa_pkg::ACT_FREE && used_ff < cnt_next) begin
                        status_in = pffa_pkg::ST_INVALID;
                     end else begin
                        status_in = pffa_pkg::ST_OK;
                        if (act_ff == pffa_pkg::ACT_UNRESERVE) begin
                           resv_in = resv_ff - cnt_next;
                        end else begin
                           used_in = used_ff - cnt_next;
                        end
                        free_in = pffa_pkg::sat_add(free_ff, cnt_next);
                        if (s_ff < hint_ff) begin
                           hint_in = s_ff;
                        end
                        state_in = S_FILL;
                     end
                  end
               end
               M_QUERY: begin
                  status_in = pffa_pkg::ST_OK;
                  etype_in = 8'(rd_type);
                  ebkt_in = rd_data[3:0];
                  state_in = S_RSP;
               end
               M_BKT: begin
                  wr_en = 1'b1;
                  wr_data = {rd_type, bkt_ff};
                  status_in = pffa_pkg::ST_OK;
                  state_in = S_RSP;
               end
               default: begin
                  state_in = S_RSP;
               end
            endcase
         end

         S_FILL: begin
            wr_en = 1'b1;
            p_in = p_ff + 1'b1;
            r_in = r_ff + 1'b1;
            if ((r_ff + 1'b1) == n_ff) begin
               state_in = S_RSP;
            end
         end

         S_RSP: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         mode_ff <= M_HINT;
         p_ff <= '0;
         hint_ff <= '0;
         free_ff <= '0;
         used_ff <= '0;
         resv_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         p_ff <= p_in;
         hint_ff <= hint_in;
         free_ff <= free_in;
         used_ff <= used_in;
         resv_ff <= resv_in;
      end
   end

   // Request payload and scan registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      aligned_ff <= aligned_in;
      below_ff <= below_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      ptype_ff <= ptype_in;
      bkt_ff <= bkt_in;
      s_ff <= s_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      wtype_ff <= wtype_in;
      status_ff <= status_in;
      base_ff <= base_in;
      etype_ff <= etype_in;
      ebkt_ff <= ebkt_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_RSP);
   assign result = '{
      status:         status_ff,
      base_address:   base_ff,
      entry_type:     etype_ff,
      entry_bucket:   ebkt_ff,
      free_count:     free_ff,
      used_count:     used_ff,
      reserved_count: resv_ff
   };

endmodule

FILE: design/page_frame_first_fit_allocator.sv
// Page frame allocator with a first-fit search over a frame map memory.
// Requests enter on the req_ stream: req_tuser carries the action, req_tdata
// the range base address, page count, page type and bucket size. Each request
// gives exactly one transaction on the rsp_ stream: status in rsp_tuser, and
// in rsp_tdata the allocated base, the queried entry and the page counters.
// Registers (lowest page, total pages, free type code) are written on the
// csr_ channel, which is always ready; write them only while the block is idle.
// One request is in work at a time. Each frame map entry visited is read, then
// evaluated, on the single memory read port; writes go one entry a cycle.
// A query or bucket write reads a single entry; a free or unreserve counts the
// range entry by entry, then rewrites it; reserve and load only write the range;
// an alloc walks entries from the hint (or from the first entry when the hint is
// not free), then stamps the run. After reset the map is cleared one entry a
// cycle, while req_tready stays low. A stalled rsp_ side holds its result in the
// output register; a new request is accepted meanwhile and waits for the slot.
module page_frame_first_fit_allocator #(
   parameter int NUM_PAGES = 65536,
   parameter int TYPE_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [47:0] address, [64:48] page_count, [72:65] page_type, [76:73] bucket_size
   input  logic [79:0]   req_tdata,
   // [2:0] action
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [47:0] base_address, [55:48] entry_type, [59:56] entry_bucket,
   // [76:60] free_count, [93:77] used_count, [110:94] reserved_count
   output logic [111:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [35:0]   csr_data
);

   pffa_pkg::cfg_type    cfg_ff, cfg_in;
   pffa_pkg::result_type result;
   pffa_pkg::result_type out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 idle;
   logic                 done;
   logic                 done_take;

   pffa_engine #(.NUM_PAGES(NUM_PAGES), .TYPE_BITS(TYPE_BITS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (req_tvalid && req_tready),
      .action      (req_tuser),
      .address     (req_tdata[47:0]),
      .page_count  (req_tdata[64:48]),
      .page_type   (req_tdata[72:65]),
      .bucket_size (req_tdata[76:73]),
      .idle        (idle),
      .done        (done),
      .done_take   (done_take),
      .result      (result)
   );

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pffa_pkg::REG_LOWEST_PAGE: cfg_in.lowest_page = csr_data;
            pffa_pkg::REG_TOTAL_PAGES: cfg_in.total_pages = csr_data[16:0];
            pffa_pkg::REG_FREE_CODE:   cfg_in.free_code = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Output slot: load when empty or draining
   always_comb begin
      done_take = done && (!out_valid_ff || rsp_tready);
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (done_take) begin
         out_in = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lowest_page: '0, total_pages: '0, free_code: 8'd1};
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign req_tready = idle;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_ff.status;
   assign rsp_tdata = {1'b0, out_ff.reserved_count, out_ff.used_count, out_ff.free_count,
                       out_ff.entry_bucket, out_ff.entry_type, out_ff.base_address};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // [47:0] address, [64:48] page_count, [72:65] page_type, [76:73] bucket_size
   logic [79:0]   req_tdata = '0;
   // [2:0] action
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // [47:0] base_address, [55:48] entry_type, [59:56] entry_bucket,
   // [76:60] free_count, [93:77] used_count, [110:94] reserved_count
   logic [111:0]  rsp_tdata;
   // [1:0] status
   logic [1:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [35:0]   csr_data = '0;

   page_frame_first_fit_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow frame map, counters and registers
   localparam int MAP_DEPTH = 65536;
   logic [7:0]  map_type [MAP_DEPTH];
   logic [3:0]  map_bkt [MAP_DEPTH];
   logic [35:0] cfg_lowest = '0;
   int          cfg_total = 0;
   logic [7:0]  cfg_fc = 8'd1;
   int          hint = 0;
   int          n_free = 0;
   int          n_used = 0;
   int          n_res = 0;

   pffa_pkg::result_type pending_rsp [$];
   int          mismatches = 0;
   int          rsp_seen = 0;

   function automatic int map_limit();
      return (cfg_total > MAP_DEPTH) ? MAP_DEPTH : cfg_total;
   endfunction

   function automatic bit page_free(int i);
      return map_type[i] == cfg_fc;
   endfunction

   function automatic int first_free_from(int from);
      int lim;
      lim = map_limit();
      for (int i = from; i < lim; i++)
         if (page_free(i)) return i;
      return lim;
   endfunction

   function automatic int sat17(int a, int b);
      return (a + b > 'h1FFFF) ? 'h1FFFF : a + b;
   endfunction

   function automatic void stamp(longint base, int n, logic [7:0] ty);
      for (int i = 0; i < n; i++) begin
         map_type[int'(base) + i] = ty;
         map_bkt[int'(base) + i] = 4'd0;
      end
   endfunction

   // Page index of an address; zero return when below the lowest page
   function automatic bit page_of(logic [47:0] addr, output longint idx);
      longint pg;
      pg = longint'(addr >> pffa_pkg::PAGE_SHIFT);
      idx = pg - longint'(cfg_lowest);
      return pg >= longint'(cfg_lowest);
   endfunction

   function automatic logic [1:0] alloc_run(int n, logic [7:0] ty, output logic [47:0] base);
      int lim, idx;
      bit run;
      lim = map_limit();
      base = '0;
      if (n == 0) return pffa_pkg::ST_INVALID;
      if (n_free < n) return pffa_pkg::ST_OOM;
      if (hint >= lim || !page_free(hint)) hint = first_free_from(0);
      idx = hint;
      while (idx < lim && longint'(idx) + n <= lim) begin
         run = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!page_free(idx + i)) begin
               run = 1'b0;
               idx = first_free_from(idx + i + 1);
               break;
            end
         end
         if (run) begin
            n_free -= n;
            n_used = sat17(n_used, n);
            stamp(idx, n, ty);
            base = 48'((longint'(idx) + longint'(cfg_lowest)) << pffa_pkg::PAGE_SHIFT);
            return pffa_pkg::ST_OK;
         end
      end
      return pffa_pkg::ST_OOM;
   endfunction

   function automatic logic [1:0] release_run(logic [47:0] addr, int n, bit from_res);
      longint idx;
      int cnt;
      cnt = 0;
      if (addr[11:0] != 0) return pffa_pkg::ST_INVALID;
      if (!page_of(addr, idx) || idx + n > map_limit()) return pffa_pkg::ST_INVALID;
      for (int i = 0; i < n; i++)
         if (!page_free(int'(idx) + i)) cnt++;
      if (cnt == 0) return pffa_pkg::ST_OK;
      if ((from_res ? n_res : n_used) < cnt) return pffa_pkg::ST_INVALID;
      if (from_res) n_res -= cnt;
      else n_used -= cnt;
      n_free = sat17(n_free, cnt);
      stamp(idx, n, cfg_fc);
      if (int'(idx) < hint) hint = int'(idx);
      return pffa_pkg::ST_OK;
   endfunction

   // Apply one request to the shadow state and return what the block should answer
   function automatic pffa_pkg::result_type predict_frame(logic [2:0] act, logic [47:0] addr,
                                                          int n, logic [7:0] ty,
                                                          logic [3:0] bk);
      pffa_pkg::result_type r;
      longint idx;
      r = '0;
      r.status = pffa_pkg::ST_INVALID;
      case (act)
         pffa_pkg::ACT_ALLOC: r.status = alloc_run(n, ty, r.base_address);
         pffa_pkg::ACT_FREE: r.status = release_run(addr, n, 1'b0);
         pffa_pkg::ACT_UNRESERVE: r.status = release_run(addr, n, 1'b1);
         pffa_pkg::ACT_RESERVE: begin
            if (addr[11:0] != 0) r.status = pffa_pkg::ST_INVALID;
            else if (n > n_free) r.status = pffa_pkg::ST_OOM;
            else if (!page_of(addr, idx) || idx + n > map_limit())
               r.status = pffa_pkg::ST_INVALID;
            else begin
               n_res = sat17(n_res, n);
               n_free -= n;
               stamp(idx, n, ty);
               r.status = pffa_pkg::ST_OK;
            end
         end
         pffa_pkg::ACT_LOAD: begin
            if (addr[11:0] == 0 && page_of(addr, idx) && idx + n <= map_limit()) begin
               stamp(idx, n, ty);
               if (ty == cfg_fc) n_free = sat17(n_free, n);
               else if (ty != 0) n_res = sat17(n_res, n);
               r.status = pffa_pkg::ST_OK;
            end
         end
         pffa_pkg::ACT_QUERY: begin
            if (page_of(addr, idx) && idx < map_limit()) begin
               r.entry_type = map_type[int'(idx)];
               r.entry_bucket = map_bkt[int'(idx)];
               r.status = pffa_pkg::ST_OK;
            end
         end
         pffa_pkg::ACT_BUCKET: begin
            if (page_of(addr, idx) && idx < map_limit()) begin
               map_bkt[int'(idx)] = bk;
               r.status = pffa_pkg::ST_OK;
            end
         end
         default: r.status = pffa_pkg::ST_INVALID;
      endcase
      r.free_count = 17'(n_free);
      r.used_count = 17'(n_used);
      r.reserved_count = 17'(n_res);
      return r;
   endfunction

   // Idle gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request, hold until accepted, then idle for a random gap
   task automatic send_req(logic [2:0] act, logic [47:0] addr, int n, logic [7:0] ty,
                           logic [3:0] bk, bit typed, logic [1:0] st);
      pffa_pkg::result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {3'b0, bk, ty, 17'(n), addr};
      do @(posedge clock); while (!req_tready);
      r = predict_frame(act, addr, n, ty, bk);
      if (typed) r.status = st;
      pending_rsp.push_back(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write a register once every pending transaction has drained
   task automatic write_reg(logic [1:0] idx, logic [35:0] val);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pffa_pkg::REG_LOWEST_PAGE: cfg_lowest = val;
         pffa_pkg::REG_TOTAL_PAGES: cfg_total = int'(val[16:0]);
         pffa_pkg::REG_FREE_CODE: cfg_fc = val[7:0];
         default: ;
      endcase
   endtask

   // Random request, biased to legal ranges around the tracked window
   task automatic random_req(int span_lo, int span_hi);
      logic [2:0]  act;
      logic [47:0] addr;
      int          n, r, lim;
      logic [7:0]  ty;
      r = $urandom_range(0, 99);
      lim = map_limit();
      act = (r < 25) ? pffa_pkg::ACT_ALLOC : (r < 40) ? pffa_pkg::ACT_FREE :
            (r < 50) ? pffa_pkg::ACT_RESERVE : (r < 60) ? pffa_pkg::ACT_UNRESERVE :
            (r < 75) ? pffa_pkg::ACT_LOAD : (r < 87) ? pffa_pkg::ACT_QUERY :
            (r < 97) ? pffa_pkg::ACT_BUCKET : 3'd7;
      addr = 48'((longint'(cfg_lowest) + $urandom_range(span_lo, span_hi))
                 << pffa_pkg::PAGE_SHIFT);
      r = $urandom_range(0, 99);
      if (r < 8) addr = {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
      else if (r < 16) addr = addr + $urandom_range(1, 'hFFF);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 'h1FFFF)
                                         : $urandom_range(0, lim / 4 + 2);
      if (lim > 256 && n > 64 && $urandom_range(0, 3) != 0) n = $urandom_range(0, 64);
      ty = 8'($urandom());
      if (act == pffa_pkg::ACT_LOAD) begin
         r = $urandom_range(0, 99);
         if (r < 55) ty = cfg_fc;
         else if (r < 70) ty = 8'd0;
      end
      send_req(act, addr, n, ty, 4'($urandom()), 1'b0, pffa_pkg::ST_OK);
   endtask

   // Directed rows: register writes and requests, some with a typed status
   typedef struct {
      bit          is_reg;
      logic [2:0]  act;
      logic [47:0] addr;
      int          n;
      logic [7:0]  ty;
      logic [3:0]  bk;
      bit          typed;
      logic [1:0]  st;
   } stim_row_type;

   stim_row_type stim_rows [$];

   function automatic void row(bit is_reg, logic [2:0] act, logic [47:0] addr, int n,
                               logic [7:0] ty, logic [3:0] bk, bit typed, logic [1:0] st);
      stim_rows.push_back('{is_reg, act, addr, n, ty, bk, typed, st});
   endfunction

   localparam logic [47:0] B = 48'h10 << pffa_pkg::PAGE_SHIFT;
   localparam logic [47:0] PG = 48'h1000;

   // Drain results and compare field by field
   always @(posedge clock) begin
      pffa_pkg::result_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen <= rsp_seen + 1;
         a.status = rsp_tuser;
         a.base_address = rsp_tdata[47:0];
         a.entry_type = rsp_tdata[55:48];
         a.entry_bucket = rsp_tdata[59:56];
         a.free_count = rsp_tdata[76:60];
         a.used_count = rsp_tdata[93:77];
         a.reserved_count = rsp_tdata[110:94];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", a);
         end else begin
            e = pending_rsp.pop_front();
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, a);
            end
         end
      end
   end

   // Receiver: random stalls, and one long hold-off to back the block up
   initial begin
      int stall;
      bit held;
      stall = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_seen >= 600) begin
            held = 1'b1;
            stall = 500;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            rsp_tready <= (stall == 0);
         end
      end
   end

   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      foreach (map_type[i]) begin
         map_type[i] = 8'd0;
         map_bkt[i] = 4'd0;
      end

      // Reset configuration: nothing tracked
      row(0, pffa_pkg::ACT_QUERY, 48'h0, 0, 8'd0, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 1, 8'd2, 4'd0, 1, pffa_pkg::ST_OOM);
      row(0, 3'd7, 48'h0, 0, 8'd0, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(1, 3'(pffa_pkg::REG_LOWEST_PAGE), 48'h10, 0, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(1, 3'(pffa_pkg::REG_TOTAL_PAGES), 48'd64, 0, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(1, 3'(pffa_pkg::REG_FREE_CODE), 48'd1, 0, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      // Bring the window up, then probe the edges
      row(0, pffa_pkg::ACT_LOAD, B, 64, 8'd1, 4'd0, 1, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 0, 8'd3, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 65, 8'd3, 4'd0, 1, pffa_pkg::ST_OOM);
      row(0, pffa_pkg::ACT_LOAD, B + 1, 1, 8'd1, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_LOAD, 48'h0, 1, 8'd1, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_LOAD, B, 65, 8'd1, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 64, 8'd3, 4'd0, 1, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_FREE, B, 64, 8'd0, 4'd0, 1, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_RESERVE, B + 3 * PG, 65, 8'h80, 4'd0, 1, pffa_pkg::ST_OOM);
      row(0, pffa_pkg::ACT_RESERVE, B + 60 * PG, 8, 8'h80, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_RESERVE, B + 4 * PG, 4, 8'h80, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_UNRESERVE, B + 4 * PG, 4, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_FREE, B, 4, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 2, 8'h7F, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_UNRESERVE, B, 2, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_BUCKET, B + 63 * PG + 48'hFFF, 0, 8'd0, 4'hF, 1, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_QUERY, B + 63 * PG, 0, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_QUERY, B + 64 * PG, 0, 8'd0, 4'd0, 1, pffa_pkg::ST_INVALID);
      row(0, pffa_pkg::ACT_LOAD, B, 0, 8'd9, 4'd0, 1, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_LOAD, B + 10 * PG, 2, 8'd0, 4'd0, 0, pffa_pkg::ST_OK);
      row(0, pffa_pkg::ACT_ALLOC, 48'h0, 1, 8'hFF, 4'd0, 0, pffa_pkg::ST_OK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_reg)
            write_reg(stim_rows[i].act[1:0], stim_rows[i].addr[35:0]);
         else
            send_req(stim_rows[i].act, stim_rows[i].addr, stim_rows[i].n, stim_rows[i].ty,
                     stim_rows[i].bk, stim_rows[i].typed, stim_rows[i].st);
      end

      // Small window at zero, free code at the top
      write_reg(pffa_pkg::REG_LOWEST_PAGE, 36'h0);
      write_reg(pffa_pkg::REG_TOTAL_PAGES, 36'd32);
      write_reg(pffa_pkg::REG_FREE_CODE, 36'hFF);
      repeat (500) random_req(0, 34);

      // Window at the top of the page space, free code zero
      write_reg(pffa_pkg::REG_LOWEST_PAGE, 36'hF_FFFF_FFC0);
      write_reg(pffa_pkg::REG_TOTAL_PAGES, 36'd64);
      write_reg(pffa_pkg::REG_FREE_CODE, 36'h0);
      repeat (400) random_req(0, 63);

      // Oversized total: full map, saturating counters
      write_reg(pffa_pkg::REG_LOWEST_PAGE, 36'h0);
      write_reg(pffa_pkg::REG_TOTAL_PAGES, 36'h1FFFF);
      write_reg(pffa_pkg::REG_FREE_CODE, 36'h5A);
      send_req(pffa_pkg::ACT_LOAD, 48'h0, 65536, 8'h5A, 4'd0, 1'b0, pffa_pkg::ST_OK);
      send_req(pffa_pkg::ACT_LOAD, 48'h0, 65536, 8'h5A, 4'd0, 1'b0, pffa_pkg::ST_OK);
      send_req(pffa_pkg::ACT_ALLOC, 48'h0, 3, 8'h11, 4'd0, 1'b0, pffa_pkg::ST_OK);
      send_req(pffa_pkg::ACT_QUERY, 48'(65535) << pffa_pkg::PAGE_SHIFT, 0, 8'd0, 4'd0,
               1'b0, pffa_pkg::ST_OK);
      send_req(pffa_pkg::ACT_QUERY, 48'(65536) << pffa_pkg::PAGE_SHIFT, 0, 8'd0, 4'd0,
               1'b1, pffa_pkg::ST_INVALID);
      send_req(pffa_pkg::ACT_BUCKET, 48'(65535) << pffa_pkg::PAGE_SHIFT, 0, 8'd0, 4'hA,
               1'b0, pffa_pkg::ST_OK);
      send_req(pffa_pkg::ACT_RESERVE, 48'h10000, 65536, 8'h22, 4'd0, 1'b1,
               pffa_pkg::ST_INVALID);
      repeat (20) random_req(0, 32);
      repeat (10) random_req(65500, 65536);

      // Mid-size window at an odd base
      write_reg(pffa_pkg::REG_LOWEST_PAGE, 36'h5_A5A5_A5A5);
      write_reg(pffa_pkg::REG_TOTAL_PAGES, 36'd256);
      write_reg(pffa_pkg::REG_FREE_CODE, 36'h3C);
      repeat (550) random_req(0, 260);

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/pffa_pkg.sv
design/pffa_ram.sv
design/pffa_engine.sv
design/page_frame_first_fit_allocator.sv
verif/tb_top.sv
